// ===== hw/rtl/hqvg_pkg.sv =====
// Shared constants, types and helpers for the hemisphere quad vertex generator.
// No dependencies.
package hqvg_pkg;

    localparam int IDX_W      = 6;
    localparam int RADIUS_W   = 16;
    localparam int RESCFG_W   = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CORNER_W   = 3;
    localparam int POS_W      = 17;
    localparam int NORM_W     = 16;
    localparam int TEX_W      = 17;
    localparam int VN_W       = 15;
    localparam int TRIG_W     = 18;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;

    // reciprocal divider: quotient = (num * recip) >> RCP_S, then one fix-up
    localparam int NUM_W = 23;
    localparam int RCP_S = 24;
    localparam int RCP_W = 25;

    // quarter-wave sine polynomial, Q2.30
    localparam logic [31:0] CA1 = 32'd1686629713;
    localparam logic [31:0] CA3 = 32'd693598668;
    localparam logic [31:0] CA5 = 32'd85569306;
    localparam logic [31:0] CA7 = 32'd5026995;
    localparam logic [31:0] CA9 = 32'd172272;

    // corner order (theta step, phi step): (1,0) (0,0) (1,1) (0,0) (0,1) (1,1)
    localparam logic [5:0] CORNER_DLON = 6'b100101;
    localparam logic [5:0] CORNER_DLAT = 6'b110100;
    localparam logic [CORNER_W-1:0] CORNER_FIRST = 3'd0;
    localparam logic [CORNER_W-1:0] CORNER_LAST  = 3'd5;

    localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

    localparam int DIV_LAT = 3;
    localparam int SIN_LAT = 8;

    typedef struct packed {
        logic [CORNER_W-1:0] corner;
        logic                last;
        logic                oor;
        logic [VN_W-1:0]     vn;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
    } vtx_meta_t;

    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [20:0] v);
        logic signed [NORM_W-1:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[NORM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hqvg_div.sv =====
// Pipelined divide by the configured resolution through a stored reciprocal.
// Depends on hqvg_pkg. Advances on en.
module hqvg_div
    import hqvg_pkg::*;
#(
    parameter int RW = 7
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [RW-1:0]    res,
    input  logic [RCP_W-1:0] recip,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W+RCP_W-1:0] prod_reg;
    logic [NUM_W-1:0]       num_a_reg;
    logic [NUM_W-1:0]       q_b_reg;
    logic [NUM_W-1:0]       qr_b_reg;
    logic [NUM_W-1:0]       num_b_reg;
    logic [NUM_W-1:0]       q_est;
    logic [NUM_W-1:0]       rem;
    logic [NUM_W-1:0]       quo_reg;

    // estimate is exact or one low
    assign q_est = prod_reg[RCP_S +: NUM_W];
    assign rem   = num_b_reg - qr_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= (NUM_W+RCP_W)'(num) * (NUM_W+RCP_W)'(recip);
            num_a_reg <= num;
            q_b_reg   <= q_est;
            qr_b_reg  <= NUM_W'(q_est * NUM_W'(res));
            num_b_reg <= num_a_reg;
            quo_reg   <= (rem >= NUM_W'(res)) ? q_b_reg + NUM_W'(1) : q_b_reg;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== hw/rtl/hqvg_sine.sv =====
// Pipelined sine of an angle code by a quarter-wave odd polynomial.
// Depends on hqvg_pkg. Advances on en.
module hqvg_sine
    import hqvg_pkg::*;
#(
    parameter int ANGLE_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ANGLE_BITS-1:0]    code,
    output logic signed [TRIG_W-1:0] sine
);

    logic [ANGLE_BITS-3:0] frac;
    logic [16:0]           x_in;
    logic [16:0]           x_reg [1:6];
    logic                  neg_reg [1:7];
    logic [16:0]           x2_reg [2:5];
    logic [31:0]           t_reg [3:7];
    logic [33:0]           xx;
    logic [48:0]           p3, p4, p5, p6, p7;
    logic [31:0]           rnd;
    logic signed [TRIG_W-1:0] sine_reg;

    assign frac = code[ANGLE_BITS-3:0];

    always_comb begin
        x_in = 17'(frac) << (18 - ANGLE_BITS);
        if (code[ANGLE_BITS-2]) begin
            x_in = 17'd65536 - x_in;
        end
    end

    assign xx  = 34'(x_reg[1]) * 34'(x_reg[1]);
    assign p3  = 49'(CA9) * 49'(x2_reg[2]);
    assign p4  = 49'(t_reg[3]) * 49'(x2_reg[3]);
    assign p5  = 49'(t_reg[4]) * 49'(x2_reg[4]);
    assign p6  = 49'(t_reg[5]) * 49'(x2_reg[5]);
    assign p7  = 49'(t_reg[6]) * 49'(x_reg[6]);
    assign rnd = t_reg[7] + 32'd16384;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[1]   <= x_in;
            neg_reg[1] <= code[ANGLE_BITS-1];
            for (int i = 2; i <= 6; i++) begin
                x_reg[i] <= x_reg[i-1];
            end
            for (int i = 2; i <= 7; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
            x2_reg[2] <= xx[32:16];
            for (int i = 3; i <= 5; i++) begin
                x2_reg[i] <= x2_reg[i-1];
            end
            t_reg[3] <= CA7 - p3[47:16];
            t_reg[4] <= CA5 - p4[47:16];
            t_reg[5] <= CA3 - p5[47:16];
            t_reg[6] <= CA1 - p6[47:16];
            t_reg[7] <= p7[47:16];
            sine_reg <= neg_reg[7] ? -$signed(TRIG_W'(rnd[31:15]))
                                   : $signed(TRIG_W'(rnd[31:15]));
        end
    end

    assign sine = sine_reg;

endmodule

// ===== hw/rtl/hemisphere_quad_vertex_generator.sv =====
// Hemisphere quad vertex generator: top level.
// Depends on hqvg_pkg, hqvg_div and hqvg_sine.
//
// Each accepted cell (longitude step, latitude step) yields six vertex transfers,
// two triangles in corner order (1,0) (0,0) (1,1) (0,0) (0,1) (1,1), carrying
// position (Q8.8), unit normal (Q1.15), texture coordinates (Q1.16) and vertex
// number; m_last marks the sixth. The result channel carries one vertex per cycle
// while the output keeps up. The next cell is accepted in the cycle the current
// one issues its sixth vertex, so cells follow with no gap. Vertices pass a
// 15-stage pipeline (reciprocal dividers, sine polynomials, products, rounding)
// that moves as one and halts only while an output transfer is stalled. Radius
// and resolution are to be written on the cfg port only while the block is idle;
// the block itself does not enforce this. A zero in the low RESCFG_W bits of the
// resolution acts as one, values there above MAX_RES act as MAX_RES. Indexes at
// or above resolution still give six vertices with m_out_of_range set.
module hemisphere_quad_vertex_generator
    import hqvg_pkg::*;
#(
    parameter int MAX_RES    = 64,
    parameter int ANGLE_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // cell input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [IDX_W-1:0]         s_lon_index,
    input  logic [IDX_W-1:0]         s_lat_index,
    // vertex output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CORNER_W-1:0]      m_corner,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_y,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic signed [NORM_W-1:0] m_norm_x,
    output logic signed [NORM_W-1:0] m_norm_y,
    output logic signed [NORM_W-1:0] m_norm_z,
    output logic [TEX_W-1:0]         m_tex_u,
    output logic [TEX_W-1:0]         m_tex_v,
    output logic [VN_W-1:0]          m_vertex_number,
    output logic                     m_last,
    output logic                     m_out_of_range
);

    localparam int RW      = $clog2(MAX_RES + 1);
    localparam int CW      = (RW > IDX_W) ? RW : IDX_W;
    localparam int RES_RST = (MAX_RES < 16) ? MAX_RES : 16;
    localparam int RCP_RST = (1 << RCP_S) / RES_RST;
    localparam int TURN    = 1 << ANGLE_BITS;
    localparam int QUARTER = TURN / 4;
    // pipeline slots: 0 issue, 1..3 divide, 4..11 sine, 12 products, 13 scale
    localparam int TEX_SLOT  = DIV_LAT + 1;
    localparam int PROD_SLOT = DIV_LAT + SIN_LAT + 1;
    localparam int PIPE_N    = PROD_SLOT + 2;

    // ---------------- configuration ----------------
    logic [RADIUS_W-1:0] radius_reg;
    logic [RW-1:0]       res_reg;
    logic [RCP_W-1:0]    recip_reg;
    logic [RW-1:0]       res_sat;
    logic [RCP_W-1:0]    recip_tab [MAX_RES+1];
    logic                cfg_we;

    for (genvar g = 0; g <= MAX_RES; g++) begin : g_rcp
        localparam int RV = (1 << RCP_S) / ((g == 0) ? 1 : g);
        assign recip_tab[g] = RCP_W'(RV);
    end

    always_comb begin
        priority if (cfg_data[RESCFG_W-1:0] == '0) begin
            res_sat = RW'(1);
        end else if (int'(cfg_data[RESCFG_W-1:0]) > MAX_RES) begin
            res_sat = RW'(MAX_RES);
        end else begin
            res_sat = RW'(cfg_data[RESCFG_W-1:0]);
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // ---------------- cell register and corner sequencer ----------------
    logic                en;
    logic                cell_vld_reg;
    logic [CORNER_W-1:0] corner_reg;
    logic [IDX_W-1:0]    lon_reg, lat_reg;
    logic                oor_reg;
    logic [VN_W-1:0]     base_reg;
    logic                issue_last;
    logic                s_accept;
    logic                oor_next;
    logic [VN_W-1:0]     base_next;
    logic [VN_W-1:0]     cell_num;

    // whole pipeline moves unless the output transfer is stalled
    assign en         = !m_valid || m_ready;
    assign issue_last = (corner_reg == CORNER_LAST);
    assign s_ready    = !cell_vld_reg || (en && issue_last);
    assign s_accept   = s_valid && s_ready;

    assign oor_next  = (CW'(s_lon_index) >= CW'(res_reg)) || (CW'(s_lat_index) >= CW'(res_reg));
    assign cell_num  = VN_W'(s_lon_index) * VN_W'(res_reg) + VN_W'(s_lat_index);
    assign base_next = cell_num * VN_W'(6);

    // ---------------- issue slot: step counts and divider numerators ----------------
    logic [IDX_W:0]     kl, kp;
    logic [NUM_W-1:0]   n_th_reg, n_ph_reg, n_u_reg, n_v_reg;
    vtx_meta_t          meta_reg [PIPE_N];
    logic               vld_reg  [PIPE_N];
    vtx_meta_t          issue_meta;

    assign kl = (IDX_W+1)'(lon_reg) + (IDX_W+1)'(CORNER_DLON[corner_reg]);
    assign kp = (IDX_W+1)'(lat_reg) + (IDX_W+1)'(CORNER_DLAT[corner_reg]);

    always_comb begin
        issue_meta        = '0;
        issue_meta.corner = corner_reg;
        issue_meta.last   = issue_last;
        issue_meta.oor    = oor_reg;
        issue_meta.vn     = base_reg + VN_W'(corner_reg);
    end

    // ---------------- dividers ----------------
    logic [NUM_W-1:0] q_th, q_ph, q_u, q_v;

    hqvg_div #(.RW(RW)) u_div_th (
        .aclk(aclk), .en(en), .num(n_th_reg), .res(res_reg), .recip(recip_reg), .quo(q_th)
    );
    hqvg_div #(.RW(RW)) u_div_ph (
        .aclk(aclk), .en(en), .num(n_ph_reg), .res(res_reg), .recip(recip_reg), .quo(q_ph)
    );
    hqvg_div #(.RW(RW)) u_div_u (
        .aclk(aclk), .en(en), .num(n_u_reg), .res(res_reg), .recip(recip_reg), .quo(q_u)
    );
    hqvg_div #(.RW(RW)) u_div_v (
        .aclk(aclk), .en(en), .num(n_v_reg), .res(res_reg), .recip(recip_reg), .quo(q_v)
    );

    // theta code is the rounded quotient; phi divides by 4R, i.e. quotient >> 2
    logic [ANGLE_BITS-1:0] th_code, ph_code, th_cos_code, ph_cos_code;
    logic [TEX_W-1:0]      tex_u_sat, tex_v_sat;
    vtx_meta_t             tex_meta;

    assign th_code     = q_th[ANGLE_BITS-1:0];
    assign ph_code     = q_ph[ANGLE_BITS+1:2];
    assign th_cos_code = th_code + ANGLE_BITS'(QUARTER);
    assign ph_cos_code = ph_code + ANGLE_BITS'(QUARTER);
    assign tex_u_sat   = (q_u > NUM_W'(TEX_ONE)) ? TEX_ONE : q_u[TEX_W-1:0];
    assign tex_v_sat   = (q_v > NUM_W'(TEX_ONE)) ? TEX_ONE : q_v[TEX_W-1:0];

    // texture quotients join the vertex as it leaves the dividers
    always_comb begin
        tex_meta       = meta_reg[TEX_SLOT-1];
        tex_meta.tex_u = tex_u_sat;
        tex_meta.tex_v = tex_v_sat;
    end

    // ---------------- trig ----------------
    logic signed [TRIG_W-1:0] ct, st, cp, sp;

    hqvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_th (
        .aclk(aclk), .en(en), .code(th_cos_code), .sine(ct)
    );
    hqvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_th (
        .aclk(aclk), .en(en), .code(th_code), .sine(st)
    );
    hqvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ph (
        .aclk(aclk), .en(en), .code(ph_cos_code), .sine(cp)
    );
    hqvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ph (
        .aclk(aclk), .en(en), .code(ph_code), .sine(sp)
    );

    // ---------------- products and scaling ----------------
    logic signed [2*TRIG_W-1:0] px_reg, pz_reg;
    logic signed [TRIG_W-1:0]   cp_reg;
    logic signed [52:0]         rpx_reg, rpz_reg;
    logic signed [34:0]         rcp_reg;
    logic signed [NORM_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic signed [RADIUS_W:0]   r_s;
    logic signed [2*TRIG_W-1:0] px_rnd, pz_rnd;
    logic signed [52:0]         rpx_rnd, rpz_rnd;
    logic signed [34:0]         rcp_rnd;

    assign r_s     = $signed({1'b0, radius_reg});
    assign px_rnd  = (px_reg + (36'sd1 <<< 14)) >>> 15;
    assign pz_rnd  = (pz_reg + (36'sd1 <<< 14)) >>> 15;
    assign rpx_rnd = (rpx_reg + (53'sd1 <<< 29)) >>> 30;
    assign rpz_rnd = (rpz_reg + (53'sd1 <<< 29)) >>> 30;
    assign rcp_rnd = (rcp_reg + (35'sd1 <<< 14)) >>> 15;

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= RADIUS_RST;
            res_reg      <= RW'(RES_RST);
            recip_reg    <= RCP_W'(RCP_RST);
            cell_vld_reg <= 1'b0;
            corner_reg   <= CORNER_FIRST;
            m_valid      <= 1'b0;
            for (int i = 0; i < PIPE_N; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_RADIUS: begin
                        radius_reg <= cfg_data[RADIUS_W-1:0];
                    end
                    REG_RESOLUTION: begin
                        res_reg   <= res_sat;
                        recip_reg <= recip_tab[res_sat];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_accept) begin
                cell_vld_reg <= 1'b1;
                corner_reg   <= CORNER_FIRST;
            end else if (en && cell_vld_reg) begin
                if (issue_last) begin
                    cell_vld_reg <= 1'b0;
                end else begin
                    corner_reg <= corner_reg + CORNER_W'(1);
                end
            end

            if (en) begin
                vld_reg[0] <= cell_vld_reg;
                for (int i = 1; i < PIPE_N; i++) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
                m_valid <= vld_reg[PIPE_N-1];
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lon_reg  <= s_lon_index;
            lat_reg  <= s_lat_index;
            oor_reg  <= oor_next;
            base_reg <= base_next;
        end

        if (en) begin
            n_th_reg <= (NUM_W'(kl) << ANGLE_BITS) + NUM_W'(res_reg >> 1);
            n_ph_reg <= (NUM_W'(kp) << ANGLE_BITS) + (NUM_W'(res_reg) << 1);
            n_u_reg  <= (NUM_W'(kp) << 16) + NUM_W'(res_reg >> 1);
            n_v_reg  <= (NUM_W'(kl) << 16) + NUM_W'(res_reg >> 1);

            meta_reg[0] <= issue_meta;
            for (int i = 1; i < PIPE_N; i++) begin
                if (i == TEX_SLOT) begin
                    meta_reg[i] <= tex_meta;
                end else begin
                    meta_reg[i] <= meta_reg[i-1];
                end
            end

            px_reg <= ct * sp;
            pz_reg <= st * sp;
            cp_reg <= cp;

            rpx_reg <= r_s * px_reg;
            rpz_reg <= r_s * pz_reg;
            rcp_reg <= r_s * cp_reg;
            nx_reg  <= sat_norm(px_rnd[20:0]);
            nz_reg  <= sat_norm(pz_rnd[20:0]);
            ny_reg  <= sat_norm(21'(cp_reg));

            m_corner        <= meta_reg[PIPE_N-1].corner;
            m_last          <= meta_reg[PIPE_N-1].last;
            m_out_of_range  <= meta_reg[PIPE_N-1].oor;
            m_vertex_number <= meta_reg[PIPE_N-1].vn;
            m_tex_u         <= meta_reg[PIPE_N-1].tex_u;
            m_tex_v         <= meta_reg[PIPE_N-1].tex_v;
            m_pos_x         <= rpx_rnd[POS_W-1:0];
            m_pos_z         <= rpz_rnd[POS_W-1:0];
            m_pos_y         <= rcp_rnd[POS_W-1:0];
            m_norm_x        <= nx_reg;
            m_norm_y        <= ny_reg;
            m_norm_z        <= nz_reg;
        end
    end

endmodule
